/* rtl/spectrum_band_level_meter_assert.svh */
// ----------------------------------------------------------------------------
// Spectrum band level meter assertion macros
// Shared concurrent assertion forms for the band meter RTL.
// ----------------------------------------------------------------------------
`ifndef SPECTRUM_BAND_LEVEL_METER_ASSERT_SVH
`define SPECTRUM_BAND_LEVEL_METER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SBLM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sblm assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SBLM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sblm assertion failed");

`endif

/* rtl/sblm_pkg.sv */
// ----------------------------------------------------------------------------
// Spectrum band level meter package
// Widths, constants, band map, microcode types and the control program.
// ----------------------------------------------------------------------------
package sblm_pkg;

  localparam int BAND_W = 3;
  localparam int BIN_W  = 9;
  localparam int MAG_W  = 16;
  localparam int AMP_W  = 16;
  localparam int VOL_W  = 19;
  localparam int CFG_W  = 8;
  localparam int PROD_W = VOL_W + CFG_W;   // operand times decay factor
  localparam int DIV_SHIFT = 3;             // 200 = 8 * 25
  localparam int XW     = PROD_W - DIV_SHIFT;
  localparam int QUO_W  = 20;
  localparam int RCP_SHIFT = 24;

  localparam logic [BIN_W-1:0] TOP_BIN      = 9'd126;
  localparam logic [AMP_W-1:0] AMP_MAX      = 16'd65535;
  localparam logic [VOL_W-1:0] VOL_MAX      = 19'd524280;
  localparam logic [QUO_W-1:0] RECIP25      = 20'd671088;  // floor(2^24 / 25)
  localparam logic [XW-1:0]    DIV25        = 24'd25;
  localparam logic [CFG_W-1:0] DECAY_RESET  = 8'd180;
  localparam logic [CFG_W-1:0] PERIOD_RESET = 8'd5;

  localparam logic CFG_DECAY  = 1'b0;
  localparam logic CFG_PERIOD = 1'b1;
  localparam logic ACT_BIN    = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  localparam logic [6:0] BAND_START [8] = '{7'd0, 7'd1, 7'd3, 7'd6,
                                            7'd12, 7'd22, 7'd40, 7'd71};

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_RCP, S_COR, S_EMIT, S_VMUL, S_VRCP, S_VCOR, S_VEMIT
  } step_t;

  typedef enum logic [1:0] {
    COND_NONE, COND_WAIT, COND_MORE, COND_ALWAYS
  } cond_t;

  typedef struct packed {
    logic  ready;
    logic  ld_prod;
    logic  vol_sel;
    logic  ld_recip;
    logic  upd_band;
    logic  upd_vol;
    logic  emit_band;
    logic  emit_last;
    cond_t cond;
    step_t target;
  } ctl_t;

  typedef struct packed {
    logic              ld_prod;
    logic              vol_sel;
    logic              ld_recip;
    logic              upd_band;
    logic              upd_vol;
    logic              load_out;
    logic              out_last;
    logic [BAND_W-1:0] band;
  } cmd_t;

  function automatic logic [BAND_W-1:0] band_of_bin(input logic [BIN_W-1:0] bin);
    logic [BAND_W-1:0] b;
    b = '0;
    for (int k = 0; k < 8; k++) begin
      if (bin >= {2'b00, BAND_START[k]}) b = BAND_W'(k);
    end
    return b;
  endfunction

  // Control program: one word per step.
  function automatic ctl_t ucode(input step_t s);
    ctl_t w;
    w = '{ready: 1'b0, ld_prod: 1'b0, vol_sel: 1'b0, ld_recip: 1'b0,
          upd_band: 1'b0, upd_vol: 1'b0, emit_band: 1'b0, emit_last: 1'b0,
          cond: COND_NONE, target: S_IDLE};
    unique case (s)
      S_IDLE: begin
        w.ready = 1'b1;
        w.cond = COND_WAIT;
        w.target = S_IDLE;
      end
      S_MUL:   w.ld_prod = 1'b1;
      S_RCP:   w.ld_recip = 1'b1;
      S_COR:   w.upd_band = 1'b1;
      S_EMIT: begin
        w.emit_band = 1'b1;
        w.cond = COND_MORE;
        w.target = S_MUL;
      end
      S_VMUL: begin
        w.ld_prod = 1'b1;
        w.vol_sel = 1'b1;
      end
      S_VRCP:  w.ld_recip = 1'b1;
      S_VCOR:  w.upd_vol = 1'b1;
      S_VEMIT: begin
        w.emit_last = 1'b1;
        w.cond = COND_ALWAYS;
        w.target = S_IDLE;
      end
      default: begin
        w.cond = COND_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/sblm_bin_accum.sv */
// ----------------------------------------------------------------------------
// Band accumulator
// Sums bins into bands, latches levels on frame end and holds band peaks.
// ----------------------------------------------------------------------------
module sblm_bin_accum #(
  parameter int NUM_BANDS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          bin_we,
  input  logic [sblm_pkg::BIN_W-1:0]    bin_index,
  input  logic [sblm_pkg::MAG_W-1:0]    bin_magnitude,
  input  logic                          frame_end,
  input  logic                          rearm,
  input  logic [sblm_pkg::BAND_W-1:0]   sel_band,
  output logic [sblm_pkg::AMP_W-1:0]    peak_sel
);

  logic [sblm_pkg::AMP_W-1:0] acc_r [NUM_BANDS];
  logic [sblm_pkg::AMP_W-1:0] acc_nxt [NUM_BANDS];
  logic [sblm_pkg::AMP_W-1:0] lvl_r [NUM_BANDS];
  logic [sblm_pkg::AMP_W-1:0] lvl_nxt [NUM_BANDS];
  logic [sblm_pkg::AMP_W-1:0] pk_r [NUM_BANDS];
  logic [sblm_pkg::AMP_W-1:0] pk_nxt [NUM_BANDS];
  logic [sblm_pkg::AMP_W:0]   sum_w [NUM_BANDS];
  logic                       in_range;
  logic [sblm_pkg::BAND_W-1:0] bin_band;

  assign in_range = bin_we && (bin_index <= sblm_pkg::TOP_BIN);
  assign bin_band = sblm_pkg::band_of_bin(bin_index);

  always_comb begin
    for (int i = 0; i < NUM_BANDS; i++) begin
      acc_nxt[i] = acc_r[i];
      lvl_nxt[i] = lvl_r[i];
      sum_w[i]   = {1'b0, acc_r[i]} + {1'b0, bin_magnitude};
      if (in_range && bin_band == sblm_pkg::BAND_W'(i)) begin
        acc_nxt[i] = sum_w[i][sblm_pkg::AMP_W] ? sblm_pkg::AMP_MAX
                                                : sum_w[i][sblm_pkg::AMP_W-1:0];
      end
      // The bin of a frame end is summed before the latch.
      if (bin_we && frame_end) begin
        lvl_nxt[i] = acc_nxt[i];
        acc_nxt[i] = '0;
      end
      pk_nxt[i] = (lvl_nxt[i] > pk_r[i]) ? lvl_nxt[i] : pk_r[i];
      if (rearm && sel_band == sblm_pkg::BAND_W'(i)) pk_nxt[i] = lvl_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BANDS; i++) begin
        acc_r[i] <= '0;
        lvl_r[i] <= '0;
        pk_r[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_BANDS; i++) begin
        acc_r[i] <= acc_nxt[i];
        lvl_r[i] <= lvl_nxt[i];
        pk_r[i]  <= pk_nxt[i];
      end
    end
  end

  always_comb begin
    peak_sel = '0;
    for (int i = 0; i < NUM_BANDS; i++) begin
      if (sel_band == sblm_pkg::BAND_W'(i)) peak_sel = pk_r[i];
    end
  end

endmodule

/* rtl/sblm_smoother.sv */
// ----------------------------------------------------------------------------
// Smoothing datapath
// Attack/decay of band amplitudes and volume, records and the result word.
// ----------------------------------------------------------------------------
`include "spectrum_band_level_meter_assert.svh"

module sblm_smoother #(
  parameter int NUM_BANDS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sblm_pkg::cmd_t                cmd,
  input  logic [sblm_pkg::CFG_W-1:0]    decay_factor,
  input  logic [sblm_pkg::AMP_W-1:0]    peak_sel,
  output logic                          slot_free,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic                          out_tlast,
  output logic [sblm_pkg::BAND_W-1:0]   out_band_number,
  output logic [sblm_pkg::AMP_W-1:0]    out_band_amplitude,
  output logic [sblm_pkg::AMP_W-1:0]    out_band_record,
  output logic [sblm_pkg::VOL_W-1:0]    out_volume_level,
  output logic [sblm_pkg::VOL_W-1:0]    out_volume_record
);

  localparam int RCP_PW = sblm_pkg::XW + sblm_pkg::QUO_W;

  logic [sblm_pkg::AMP_W-1:0]  sm_r [NUM_BANDS];
  logic [sblm_pkg::AMP_W-1:0]  atm_r [NUM_BANDS];
  logic [sblm_pkg::VOL_W-1:0]  svol_r, maxv_r, vacc_r;
  logic [sblm_pkg::PROD_W-1:0] p_r;
  logic [sblm_pkg::XW-1:0]     x_r;
  logic [sblm_pkg::QUO_W-1:0]  q0_r;

  logic                        ov_r;
  logic                        ol_r;
  logic [sblm_pkg::BAND_W-1:0] ob_r;
  logic [sblm_pkg::AMP_W-1:0]  oa_r, orec_r;
  logic [sblm_pkg::VOL_W-1:0]  ovol_r, ovrec_r;

  logic [sblm_pkg::AMP_W-1:0]  sm_sel, atm_sel, sm_new;
  logic [sblm_pkg::VOL_W-1:0]  op;
  logic [sblm_pkg::PROD_W-1:0] p_nxt;
  logic [sblm_pkg::XW-1:0]     x_nxt, q25, rem;
  logic [RCP_PW-1:0]           rcp_prod;
  logic [sblm_pkg::QUO_W-1:0]  quo;
  logic [sblm_pkg::AMP_W-1:0]  amp_dec;
  logic [sblm_pkg::VOL_W-1:0]  vol_dec;

  always_comb begin
    sm_sel  = '0;
    atm_sel = '0;
    for (int i = 0; i < NUM_BANDS; i++) begin
      if (cmd.band == sblm_pkg::BAND_W'(i)) begin
        sm_sel  = sm_r[i];
        atm_sel = atm_r[i];
      end
    end
  end

  // Divide by 200: shift out three bits, a factor of 8, then multiply by the
  // reciprocal of 25 and correct once, as the estimate is at most one too low.
  assign op       = cmd.vol_sel ? svol_r : {3'b000, sm_sel};
  assign p_nxt    = sblm_pkg::PROD_W'(op) * sblm_pkg::PROD_W'(decay_factor);
  assign x_nxt    = p_r[sblm_pkg::PROD_W-1:sblm_pkg::DIV_SHIFT];
  assign rcp_prod = RCP_PW'(x_nxt) * RCP_PW'(sblm_pkg::RECIP25);
  assign q25      = (sblm_pkg::XW'(q0_r) << 4) + (sblm_pkg::XW'(q0_r) << 3)
                    + sblm_pkg::XW'(q0_r);
  assign rem      = x_r - q25;
  assign quo      = q0_r + sblm_pkg::QUO_W'(rem >= sblm_pkg::DIV25);
  assign amp_dec  = (quo > sblm_pkg::QUO_W'(sblm_pkg::AMP_MAX)) ? sblm_pkg::AMP_MAX
                                                             : quo[sblm_pkg::AMP_W-1:0];
  assign vol_dec  = (quo > sblm_pkg::QUO_W'(sblm_pkg::VOL_MAX)) ? sblm_pkg::VOL_MAX
                                                             : quo[sblm_pkg::VOL_W-1:0];
  assign sm_new   = (peak_sel > sm_sel) ? peak_sel : amp_dec;

  always_ff @(posedge clk) begin
    if (cmd.ld_prod) p_r <= p_nxt;
    if (cmd.ld_recip) begin
      x_r  <= x_nxt;
      q0_r <= rcp_prod[RCP_PW-1:sblm_pkg::RCP_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BANDS; i++) begin
        sm_r[i]  <= '0;
        atm_r[i] <= '0;
      end
      svol_r <= '0;
      maxv_r <= '0;
      vacc_r <= '0;
    end else begin
      if (cmd.upd_band) begin
        for (int i = 0; i < NUM_BANDS; i++) begin
          if (cmd.band == sblm_pkg::BAND_W'(i)) begin
            sm_r[i] <= sm_new;
            if (peak_sel > atm_r[i]) atm_r[i] <= peak_sel;
          end
        end
        vacc_r <= vacc_r + sblm_pkg::VOL_W'(sm_new);
      end
      if (cmd.upd_vol) begin
        svol_r <= (vacc_r > svol_r) ? vacc_r : vol_dec;
        if (vacc_r > maxv_r) maxv_r <= vacc_r;
        vacc_r <= '0;
      end
    end
  end

  assign slot_free = !ov_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.load_out) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      ol_r    <= cmd.out_last;
      ob_r    <= cmd.band;
      oa_r    <= sm_sel;
      orec_r  <= atm_sel;
      ovol_r  <= cmd.out_last ? svol_r : '0;
      ovrec_r <= cmd.out_last ? maxv_r : '0;
    end
  end

  assign out_tvalid         = ov_r;
  assign out_tlast          = ol_r;
  assign out_band_number    = ob_r;
  assign out_band_amplitude = oa_r;
  assign out_band_record    = orec_r;
  assign out_volume_level   = ovol_r;
  assign out_volume_record  = ovrec_r;

  `SBLM_ASSERT_IMP(a_vol_only_last, clk, rst_n, out_tvalid && !out_tlast, out_volume_level == '0 && out_volume_record == '0)
  `SBLM_ASSERT_IMP(a_last_band, clk, rst_n, out_tvalid && out_tlast, out_band_number == sblm_pkg::BAND_W'(NUM_BANDS - 1))

endmodule

/* rtl/sblm_sequencer.sv */
// ----------------------------------------------------------------------------
// Microcode sequencer
// Step counter over the control program, tick timing and band counter.
// ----------------------------------------------------------------------------
`include "spectrum_band_level_meter_assert.svh"

module sblm_sequencer #(
  parameter int NUM_BANDS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          action,
  input  logic [sblm_pkg::CFG_W-1:0]    collect_period,
  input  logic                          slot_free,
  output logic                          in_tready,
  output sblm_pkg::cmd_t                cmd
);

  sblm_pkg::step_t              step_r, step_nxt;
  logic [sblm_pkg::BAND_W-1:0]  band_r, band_nxt;
  logic [sblm_pkg::CFG_W-1:0]   elapsed_r, elapsed_nxt;
  sblm_pkg::ctl_t               ctl;
  logic                         accept, tick, collect, band_last, jump;
  logic                         fire_band, fire_last, hold;
  logic [sblm_pkg::CFG_W:0]     ticks;

  assign ctl       = sblm_pkg::ucode(step_r);
  assign in_tready = ctl.ready;
  assign accept    = in_tvalid && ctl.ready;
  assign tick      = accept && (action == sblm_pkg::ACT_TICK);
  assign ticks     = {1'b0, elapsed_r} + 9'd1;
  assign collect   = tick && (ticks > {1'b0, collect_period});
  assign band_last = (band_r == sblm_pkg::BAND_W'(NUM_BANDS - 1));
  assign fire_band = ctl.emit_band && !band_last && slot_free;
  assign fire_last = ctl.emit_last && slot_free;
  assign hold      = (ctl.emit_band && !band_last && !slot_free)
                     || (ctl.emit_last && !slot_free);

  always_comb begin
    unique case (ctl.cond)
      sblm_pkg::COND_NONE:   jump = 1'b0;
      sblm_pkg::COND_WAIT:   jump = !collect;
      sblm_pkg::COND_MORE:   jump = !band_last;
      sblm_pkg::COND_ALWAYS: jump = 1'b1;
      default:               jump = 1'b0;
    endcase

    if (hold) begin
      step_nxt = step_r;
    end else if (jump) begin
      step_nxt = ctl.target;
    end else begin
      step_nxt = sblm_pkg::step_t'(step_r + 4'd1);
    end

    band_nxt = band_r;
    if (fire_band) band_nxt = band_r + 3'd1;
    if (fire_last) band_nxt = '0;

    elapsed_nxt = elapsed_r;
    if (tick) elapsed_nxt = collect ? '0 : ticks[sblm_pkg::CFG_W-1:0];

    cmd.ld_prod  = ctl.ld_prod;
    cmd.vol_sel  = ctl.vol_sel;
    cmd.ld_recip = ctl.ld_recip;
    cmd.upd_band = ctl.upd_band;
    cmd.upd_vol  = ctl.upd_vol;
    cmd.load_out = fire_band || fire_last;
    cmd.out_last = ctl.emit_last;
    cmd.band     = band_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= sblm_pkg::S_IDLE;
      band_r    <= '0;
      elapsed_r <= '0;
    end else begin
      step_r    <= step_nxt;
      band_r    <= band_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  `SBLM_ASSERT_NXT(a_collect_start, clk, rst_n, collect, step_r == sblm_pkg::S_MUL && elapsed_r == '0 && band_r == '0)
  `SBLM_ASSERT_IMP(a_band_range, clk, rst_n, 1'b1, band_r <= sblm_pkg::BAND_W'(NUM_BANDS - 1))

endmodule

/* rtl/spectrum_band_level_meter.sv */
// A bin word or a tick that does not collect is taken while the sequencer idles,
// so the next word may follow in the next cycle. A collecting tick holds the
// input while each band, and then the volume, passes through the shared
// multiplier and the three-step divide by 200. Each result is registered for
// output at the end of its pass; a stalled output holds the sequence.
// Synchronous active-low reset clears all band state and loads register defaults.
// ----------------------------------------------------------------------------
// Spectrum band level meter
// Band sums of FFT bins with peak hold, attack/decay smoothing and records.
// ----------------------------------------------------------------------------
module spectrum_band_level_meter #(
  parameter int NUM_BANDS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // bin_index [8:0], bin_magnitude [24:9]
  input  logic        in_tuser,   // action
  input  logic        in_tlast,   // frame_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // band_amplitude [15:0], band_record [31:16],
                                  // volume_level [50:32], volume_record [69:51]
  output logic [2:0]  out_tuser,  // band_number
  output logic        out_tlast,  // last
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  logic [sblm_pkg::CFG_W-1:0]  decay_r, period_r;
  sblm_pkg::cmd_t              cmd;
  logic [sblm_pkg::AMP_W-1:0]  peak_sel;
  logic                        slot_free, bin_we;
  logic [sblm_pkg::AMP_W-1:0]  amp, rec;
  logic [sblm_pkg::VOL_W-1:0]  vol, vrec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r  <= sblm_pkg::DECAY_RESET;
      period_r <= sblm_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      if (cfg_addr[0] == sblm_pkg::CFG_DECAY) begin
        decay_r <= cfg_wdata;
      end else begin
        period_r <= cfg_wdata;
      end
    end
  end

  assign bin_we = in_tvalid && in_tready && (in_tuser == sblm_pkg::ACT_BIN);

  sblm_sequencer #(.NUM_BANDS(NUM_BANDS)) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .action         (in_tuser),
    .collect_period (period_r),
    .slot_free      (slot_free),
    .in_tready      (in_tready),
    .cmd            (cmd)
  );

  sblm_bin_accum #(.NUM_BANDS(NUM_BANDS)) u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .bin_we        (bin_we),
    .bin_index     (in_tdata[8:0]),
    .bin_magnitude (in_tdata[24:9]),
    .frame_end     (in_tlast),
    .rearm         (cmd.upd_band),
    .sel_band      (cmd.band),
    .peak_sel      (peak_sel)
  );

  sblm_smoother #(.NUM_BANDS(NUM_BANDS)) u_smooth (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .decay_factor       (decay_r),
    .peak_sel           (peak_sel),
    .slot_free          (slot_free),
    .out_tvalid         (out_tvalid),
    .out_tready         (out_tready),
    .out_tlast          (out_tlast),
    .out_band_number    (out_tuser),
    .out_band_amplitude (amp),
    .out_band_record    (rec),
    .out_volume_level   (vol),
    .out_volume_record  (vrec)
  );

  assign out_tdata = {2'b00, vrec, vol, rec, amp};

endmodule

/* tb/sv/spectrum_band_level_meter_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Spectrum band level meter testbench
// Sends FFT bin words and millisecond ticks and predicts every collect report
// from a band, peak, smoothing and record model. Reports are compared field by
// field, under random gaps and stalls and several register settings.
// ----------------------------------------------------------------------------
module spectrum_band_level_meter_tb;

  localparam int NUM_BANDS   = 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 50;
  localparam int IDLE_WAIT   = 40;
  localparam int PRINT_CAP   = 200;

  typedef struct {
    bit [2:0]  band;
    bit [15:0] amplitude;
    bit [15:0] record;
    bit [18:0] volume;
    bit [18:0] volume_record;
    bit        last;
  } band_report_t;

  class band_meter_scoreboard;
    bit [15:0]    accum [NUM_BANDS];
    bit [15:0]    level [NUM_BANDS];
    bit [15:0]    held_peak [NUM_BANDS];
    bit [15:0]    smoothed [NUM_BANDS];
    bit [15:0]    band_max [NUM_BANDS];
    bit [18:0]    volume;
    bit [18:0]    volume_max;
    bit [7:0]     ticks;
    bit [7:0]     decay;
    bit [7:0]     period;
    band_report_t reports [$];
    int           errors;

    function new();
      for (int i = 0; i < NUM_BANDS; i++) begin
        accum[i] = '0;
        level[i] = '0;
        held_peak[i] = '0;
        smoothed[i] = '0;
        band_max[i] = '0;
      end
      volume = '0;
      volume_max = '0;
      ticks = '0;
      decay = sblm_pkg::DECAY_RESET;
      period = sblm_pkg::PERIOD_RESET;
      errors = 0;
    endfunction

    function void set_reg(bit idx, bit [7:0] value);
      if (idx == sblm_pkg::CFG_DECAY) decay = value;
      else period = value;
    endfunction

    function int band_for_bin(bit [8:0] bin);
      if (bin >= 71) return 7;
      if (bin >= 40) return 6;
      if (bin >= 22) return 5;
      if (bin >= 12) return 4;
      if (bin >= 6) return 3;
      if (bin >= 3) return 2;
      if (bin >= 1) return 1;
      return 0;
    endfunction

    // Predicts the reports caused by one accepted input word.
    function void note_word(bit action, bit [8:0] bin, bit [15:0] mag, bit fend);
      int unsigned  sum;
      int unsigned  scaled;
      int unsigned  total;
      int           b;
      band_report_t rpt;
      if (action == sblm_pkg::ACT_BIN) begin
        if (bin <= sblm_pkg::TOP_BIN) begin
          b = band_for_bin(bin);
          sum = accum[b] + mag;
          accum[b] = (sum > sblm_pkg::AMP_MAX) ? sblm_pkg::AMP_MAX : sum[15:0];
        end
        if (fend) begin
          for (int i = 0; i < NUM_BANDS; i++) begin
            level[i] = accum[i];
            accum[i] = '0;
          end
        end
      end
      for (int i = 0; i < NUM_BANDS; i++)
        if (level[i] > held_peak[i]) held_peak[i] = level[i];
      if (action != sblm_pkg::ACT_TICK) return;
      if ({1'b0, ticks} + 9'd1 <= {1'b0, period}) begin
        ticks = ticks + 8'd1;
        return;
      end
      ticks = '0;
      total = 0;
      for (int i = 0; i < NUM_BANDS; i++) begin
        if (held_peak[i] > smoothed[i]) begin
          smoothed[i] = held_peak[i];
        end else begin
          scaled = (smoothed[i] * decay) / 200;
          smoothed[i] = (scaled > sblm_pkg::AMP_MAX) ? sblm_pkg::AMP_MAX : scaled[15:0];
        end
        total += smoothed[i];
        if (held_peak[i] > band_max[i]) band_max[i] = held_peak[i];
        held_peak[i] = level[i];
      end
      if (total > volume) begin
        volume = total[18:0];
      end else begin
        scaled = (volume * decay) / 200;
        volume = (scaled > sblm_pkg::VOL_MAX) ? sblm_pkg::VOL_MAX : scaled[18:0];
      end
      if (total > volume_max) volume_max = total[18:0];
      for (int i = 0; i < NUM_BANDS; i++) begin
        rpt.band = i[2:0];
        rpt.amplitude = smoothed[i];
        rpt.record = band_max[i];
        rpt.last = (i == NUM_BANDS - 1);
        rpt.volume = rpt.last ? volume : '0;
        rpt.volume_record = rpt.last ? volume_max : '0;
        reports.push_back(rpt);
      end
    endfunction

    function void mismatch(string field, int band, int unsigned exp_v, int unsigned got_v);
      errors++;
      if (errors <= PRINT_CAP)
        $display("%0t ns: band %0d %s expected %0d actual %0d",
                 $time, band, field, exp_v, got_v);
    endfunction

    function void check_word(bit [2:0] band, bit [15:0] amp, bit [15:0] rec,
                             bit [18:0] vol, bit [18:0] vrec, bit last);
      band_report_t e;
      if (reports.size() == 0) begin
        errors++;
        if (errors <= PRINT_CAP)
          $display("%0t ns: unexpected word, band %0d amplitude %0d", $time, band, amp);
        return;
      end
      e = reports.pop_front();
      if (band != e.band) mismatch("band_number", e.band, e.band, band);
      if (amp != e.amplitude) mismatch("band_amplitude", e.band, e.amplitude, amp);
      if (rec != e.record) mismatch("band_record", e.band, e.record, rec);
      if (vol != e.volume) mismatch("volume_level", e.band, e.volume, vol);
      if (vrec != e.volume_record) mismatch("volume_record", e.band, e.volume_record, vrec);
      if (last != e.last) mismatch("last", e.band, e.last, last);
    endfunction

    function int pending();
      return reports.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we;
  logic [0:0]  cfg_addr;
  logic [7:0]  cfg_wdata;

  band_meter_scoreboard sb;
  bit steady = 1'b0;
  int stall_left = 0;
  int cycle_count = 0;

  spectrum_band_level_meter dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Output side stalls: mostly short, now and then long, no new ones while steady.
  always @(negedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (steady || r < 70) begin
      out_tready <= 1'b1;
    end else if (r < 95) begin
      stall_left <= $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      stall_left <= $urandom_range(8, 40);
      out_tready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_word(out_tuser, out_tdata[15:0], out_tdata[31:16], out_tdata[50:32],
                    out_tdata[69:51], out_tlast);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic bit [15:0] pick_magnitude();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'h0000;
    if (r < 20) return 16'hFFFF;
    if (r < 60) return 16'($urandom_range(0, 4095));
    if (r < 70) return 16'($urandom_range(0, 63));
    return 16'($urandom);
  endfunction

  // Called and left at a falling edge; valid stays up between back-to-back words.
  task automatic push_word(bit action, bit [8:0] bin, bit [15:0] mag, bit fend);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= action;
    in_tlast <= fend;
    in_tdata <= {7'b0, mag, bin};
    do @(posedge clk); while (!in_tready);
    sb.note_word(action, bin, mag, fend);
    @(negedge clk);
  endtask

  task automatic push_tick();
    push_word(sblm_pkg::ACT_TICK, 9'($urandom_range(0, 511)), 16'($urandom),
              $urandom_range(0, 4) == 0);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (IDLE_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(bit idx, bit [7:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, value);
    @(negedge clk);
  endtask

  // Frames of random bins closed by a frame end, with ticks mixed in.
  task automatic run_phase(int n_words, int tick_pct);
    int        left_in_frame;
    bit [8:0]  bin;
    bit [15:0] mag;
    bit        fend;
    steady = ($urandom_range(0, 3) == 0);
    left_in_frame = $urandom_range(2, 20);
    for (int k = 0; k < n_words; k++) begin
      if (k == n_words / 2) steady = ~steady;
      if ($urandom_range(0, 99) < tick_pct) begin
        push_tick();
      end else begin
        bin = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(127, 511))
                                          : 9'($urandom_range(0, 126));
        mag = pick_magnitude();
        left_in_frame--;
        fend = (left_in_frame <= 0) || ($urandom_range(0, 29) == 0);
        if (fend) left_in_frame = $urandom_range(2, 20);
        push_word(sblm_pkg::ACT_BIN, bin, mag, fend);
      end
    end
    settle();
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words at register defaults: field extremes, band edges,
    // accumulator saturation, ignored bins and frame end on ticks.
    push_word(sblm_pkg::ACT_BIN, 9'd0, 16'hFFFF, 1'b0);
    push_word(sblm_pkg::ACT_BIN, 9'd0, 16'h0001, 1'b0);
    push_word(sblm_pkg::ACT_BIN, 9'd126, 16'hFFFF, 1'b0);
    push_word(sblm_pkg::ACT_BIN, 9'd71, 16'h5555, 1'b0);
    push_word(sblm_pkg::ACT_BIN, 9'd127, 16'hFFFF, 1'b0);
    push_word(sblm_pkg::ACT_BIN, 9'd511, 16'hFFFF, 1'b0);
    push_word(sblm_pkg::ACT_BIN, 9'd70, 16'hAAAA, 1'b0);
    push_word(sblm_pkg::ACT_BIN, 9'd1, 16'h1234, 1'b0);
    push_word(sblm_pkg::ACT_BIN, 9'd2, 16'h0000, 1'b0);
    push_word(sblm_pkg::ACT_BIN, 9'd5, 16'h00FF, 1'b0);
    push_word(sblm_pkg::ACT_BIN, 9'd11, 16'h0F0F, 1'b0);
    push_word(sblm_pkg::ACT_BIN, 9'd21, 16'h8000, 1'b0);
    push_word(sblm_pkg::ACT_BIN, 9'd39, 16'h7FFF, 1'b0);
    // Frame end on an ignored bin still latches the levels.
    push_word(sblm_pkg::ACT_BIN, 9'd300, 16'hFFFF, 1'b1);
    push_word(sblm_pkg::ACT_TICK, 9'd0, 16'h0000, 1'b1);
    for (int k = 0; k < 5; k++) push_tick();
    push_word(sblm_pkg::ACT_BIN, 9'd64, 16'd100, 1'b1);
    for (int k = 0; k < 3; k++) push_tick();
    settle();

    write_reg(sblm_pkg::CFG_DECAY, 8'd0);
    write_reg(sblm_pkg::CFG_PERIOD, 8'd0);
    run_phase(70, 25);
    write_reg(sblm_pkg::CFG_DECAY, 8'd200);
    write_reg(sblm_pkg::CFG_PERIOD, 8'd1);
    run_phase(70, 30);
    write_reg(sblm_pkg::CFG_DECAY, 8'd255);
    write_reg(sblm_pkg::CFG_PERIOD, 8'd2);
    run_phase(70, 30);
    // A long period builds up ticks that the next, shorter period collects at once.
    write_reg(sblm_pkg::CFG_DECAY, 8'd128);
    write_reg(sblm_pkg::CFG_PERIOD, 8'd255);
    run_phase(30, 60);
    write_reg(sblm_pkg::CFG_DECAY, 8'd1);
    write_reg(sblm_pkg::CFG_PERIOD, 8'd3);
    run_phase(70, 30);
    write_reg(sblm_pkg::CFG_DECAY, 8'd180);
    write_reg(sblm_pkg::CFG_PERIOD, 8'd5);
    run_phase(80, 35);

    repeat (DRAIN_WAIT) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
